/* rtl/date_text_parse_validate_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the date text parser
// Shared property forms for the checker; all sample on clk.
// ---------------------------------------------------------------------------
`ifndef DATE_TEXT_PARSE_VALIDATE_TOP_MACROS_SVH
`define DATE_TEXT_PARSE_VALIDATE_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define DTPV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define DTPV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define DTPV_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dtpv_pkg.sv */
// ---------------------------------------------------------------------------
// dtpv_pkg
// Widths, character and field codes, request type and helper functions.
// ---------------------------------------------------------------------------
package dtpv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DAY_W   = 7;
  localparam int unsigned MONTH_W = 7;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned FIELD_W = 2;
  localparam int unsigned DCNT_W  = 3;
  localparam int unsigned MOD25_W = 5;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned DLEN_W  = 5;

  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'd47;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [FIELD_W-1:0] FLD_DAY   = 2'd0;
  localparam logic [FIELD_W-1:0] FLD_MONTH = 2'd1;
  localparam logic [FIELD_W-1:0] FLD_YEAR  = 2'd2;
  localparam logic [FIELD_W-1:0] FLD_DONE  = 2'd3;

  localparam logic [DCNT_W-1:0] DCNT_MAX_DM   = 3'd2;
  localparam logic [DCNT_W-1:0] DCNT_YEAR_S   = 3'd2;
  localparam logic [DCNT_W-1:0] DCNT_YEAR_L   = 3'd4;
  localparam logic [DCNT_W-1:0] DCNT_ACC_LIM  = 3'd4;
  localparam logic [DCNT_W-1:0] DCNT_SAT      = 3'd7;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd10;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               year_div25;   // year is a multiple of 25
  } date_req_t;

  // (r*10 + d) mod 25 with r < 25; quotient by reciprocal 41/1024
  function automatic logic [MOD25_W-1:0] mod25_step(input logic [MOD25_W-1:0] r,
                                                    input logic [3:0] d);
    logic [7:0]  x;
    logic [13:0] p;
    logic [3:0]  q;
    logic [7:0]  qm;
    x  = 8'({3'b000, r} << 3) + 8'({3'b000, r} << 1) + 8'(d);
    p  = 14'(x) * 14'd41;
    q  = p[13:10];
    qm = 8'(q) * 8'd25;
    return MOD25_W'(x - qm);
  endfunction

  // days in month; zero for a month outside 1..12
  function automatic logic [DLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DLEN_W-1:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                      len = 5'd30;
      7'd2:                                         len = leap ? 5'd29 : 5'd28;
      default:                                      len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* rtl/dtpv_ifs.sv */
// ---------------------------------------------------------------------------
// dtpv channel interfaces
// Character input channel and date result channel, valid/ready.
// ---------------------------------------------------------------------------
interface dtpv_char_if;
  logic                          valid;
  logic                          ready;
  logic [dtpv_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtpv_date_if;
  logic                          valid;
  logic                          ready;
  logic                          date_ok;
  logic [dtpv_pkg::DAY_W-1:0]    day_out;
  logic [dtpv_pkg::MONTH_W-1:0]  month_out;
  logic [dtpv_pkg::YEAR_W-1:0]   year_out;

  modport source (output valid, output date_ok, output day_out, output month_out,
                  output year_out, input ready);
  modport sink   (input valid, input date_ok, input day_out, input month_out,
                  input year_out, output ready);
endinterface

/* rtl/dtpv_front.sv */
// ---------------------------------------------------------------------------
// dtpv_front
// Character parser: splits d/m/y fields, flags errors, issues a request
// on the final character.
// ---------------------------------------------------------------------------
module dtpv_front (
  input  logic                clk,
  input  logic                rst,
  dtpv_char_if.sink           char_ch,
  input  logic                q_full,
  output logic                push,
  output dtpv_pkg::date_req_t push_data
);

  logic [dtpv_pkg::FIELD_W-1:0] field_index;
  logic [dtpv_pkg::DCNT_W-1:0]  digit_count;
  logic [dtpv_pkg::YEAR_W-1:0]  accumulator;
  logic [dtpv_pkg::MOD25_W-1:0] acc_mod25;
  logic [dtpv_pkg::DAY_W-1:0]   held_day;
  logic [dtpv_pkg::MONTH_W-1:0] held_month;
  logic                         parse_error;

  logic [dtpv_pkg::FIELD_W-1:0] field_index_next;
  logic [dtpv_pkg::DCNT_W-1:0]  digit_count_next;
  logic [dtpv_pkg::YEAR_W-1:0]  accumulator_next;
  logic [dtpv_pkg::MOD25_W-1:0] acc_mod25_next;
  logic [dtpv_pkg::DAY_W-1:0]   held_day_next;
  logic [dtpv_pkg::MONTH_W-1:0] held_month_next;
  logic                         parse_error_next;

  logic accept;
  logic is_digit;

  assign char_ch.ready = !q_full;
  assign accept        = char_ch.valid && char_ch.ready;
  assign push          = accept && char_ch.last_char;
  assign is_digit      = (char_ch.char_code >= dtpv_pkg::CHAR_ZERO) &&
                         (char_ch.char_code <= dtpv_pkg::CHAR_NINE);

  always_comb begin
    field_index_next = field_index;
    digit_count_next = digit_count;
    accumulator_next = accumulator;
    acc_mod25_next   = acc_mod25;
    held_day_next    = held_day;
    held_month_next  = held_month;
    parse_error_next = parse_error;

    if (field_index != dtpv_pkg::FLD_DONE) begin
      if (char_ch.char_code == dtpv_pkg::CHAR_SLASH) begin
        if (field_index == dtpv_pkg::FLD_YEAR) begin
          if (digit_count != dtpv_pkg::DCNT_YEAR_S && digit_count != dtpv_pkg::DCNT_YEAR_L)
            parse_error_next = 1'b1;
          field_index_next = dtpv_pkg::FLD_DONE;
        end else begin
          if (digit_count > dtpv_pkg::DCNT_MAX_DM)
            parse_error_next = 1'b1;
          else if (field_index == dtpv_pkg::FLD_DAY)
            held_day_next = accumulator[dtpv_pkg::DAY_W-1:0];
          else
            held_month_next = accumulator[dtpv_pkg::MONTH_W-1:0];
          accumulator_next = '0;
          acc_mod25_next   = '0;
          digit_count_next = '0;
          field_index_next = field_index + 2'd1;
        end
      end else if (is_digit) begin
        if (digit_count < dtpv_pkg::DCNT_ACC_LIM) begin
          accumulator_next = dtpv_pkg::YEAR_W'(accumulator << 3) +
                             dtpv_pkg::YEAR_W'(accumulator << 1) +
                             dtpv_pkg::YEAR_W'(char_ch.char_code[3:0]);
          acc_mod25_next   = dtpv_pkg::mod25_step(acc_mod25, char_ch.char_code[3:0]);
        end
        if (digit_count < dtpv_pkg::DCNT_SAT)
          digit_count_next = digit_count + 3'd1;
      end else begin
        parse_error_next = 1'b1;
        field_index_next = dtpv_pkg::FLD_DONE;
      end
    end

    // end of text: an open day or month field is an error; the year field closes here if still open
    if (field_index_next == dtpv_pkg::FLD_DAY || field_index_next == dtpv_pkg::FLD_MONTH) begin
      if (char_ch.last_char)
        parse_error_next = 1'b1;
    end else if (field_index_next == dtpv_pkg::FLD_YEAR && char_ch.last_char) begin
      if (digit_count_next != dtpv_pkg::DCNT_YEAR_S &&
          digit_count_next != dtpv_pkg::DCNT_YEAR_L)
        parse_error_next = 1'b1;
    end
  end

  always_comb begin
    if (parse_error_next) begin
      push_data = '0;
    end else begin
      push_data.day        = held_day_next;
      push_data.month      = held_month_next;
      push_data.year       = accumulator_next;
      push_data.year_div25 = (acc_mod25_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      field_index <= dtpv_pkg::FLD_DAY;
      digit_count <= '0;
      accumulator <= '0;
      acc_mod25   <= '0;
      held_day    <= '0;
      held_month  <= '0;
      parse_error <= 1'b0;
    end else if (accept) begin
      field_index <= field_index_next;
      digit_count <= digit_count_next;
      accumulator <= accumulator_next;
      acc_mod25   <= acc_mod25_next;
      held_day    <= held_day_next;
      held_month  <= held_month_next;
      parse_error <= parse_error_next;
    end
  end

endmodule

/* rtl/dtpv_queue.sv */
// ---------------------------------------------------------------------------
// dtpv_queue
// Two-entry request queue between the parser and the validator.
// ---------------------------------------------------------------------------
module dtpv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dtpv_pkg::date_req_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output dtpv_pkg::date_req_t head_data
);

  localparam int unsigned PTR_W = (dtpv_pkg::QDEPTH > 1) ? $clog2(dtpv_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(dtpv_pkg::QDEPTH + 1);

  dtpv_pkg::date_req_t entries [dtpv_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full       = (count == CNT_W'(dtpv_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push)
      entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(dtpv_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(dtpv_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)
        count <= count + CNT_W'(1);
      else if (do_pop && !do_push)
        count <= count - CNT_W'(1);
    end
  end

endmodule

/* rtl/dtpv_back.sv */
// ---------------------------------------------------------------------------
// dtpv_back
// Gregorian validator: range, month length and leap year checks, with a
// registered result stage.
// ---------------------------------------------------------------------------
module dtpv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  dtpv_pkg::date_req_t head_data,
  output logic                pop,
  dtpv_date_if.source         date_ch
);

  logic                         out_valid;
  logic                         date_ok;
  logic [dtpv_pkg::DAY_W-1:0]   day_out;
  logic [dtpv_pkg::MONTH_W-1:0] month_out;
  logic [dtpv_pkg::YEAR_W-1:0]  year_out;

  logic                         leap;
  logic                         year_in_range;
  logic [dtpv_pkg::DLEN_W-1:0]  mon_len;
  logic                         ok_next;

  // leap: divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
  assign leap = (head_data.year[1:0] == 2'b00) &&
                (!head_data.year_div25 || head_data.year[3:0] == 4'b0000);
  assign year_in_range = (head_data.year >= dtpv_pkg::YEAR_MIN) &&
                         (head_data.year <= dtpv_pkg::YEAR_MAX);
  assign mon_len = dtpv_pkg::month_days(head_data.month, leap);
  assign ok_next = year_in_range && (head_data.day != '0) &&
                   (head_data.day <= dtpv_pkg::DAY_W'(mon_len));

  assign pop = head_valid && (!out_valid || date_ch.ready);

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (!out_valid || date_ch.ready)
      out_valid <= head_valid;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      date_ok   <= ok_next;
      day_out   <= head_data.day;
      month_out <= head_data.month;
      year_out  <= head_data.year;
    end
  end

  assign date_ch.valid     = out_valid;
  assign date_ch.date_ok   = date_ok;
  assign date_ch.day_out   = day_out;
  assign date_ch.month_out = month_out;
  assign date_ch.year_out  = year_out;

endmodule

/* rtl/date_text_parse_validate_top.sv */
// ---------------------------------------------------------------------------
// date_text_parse_validate_top
// Parses a d/m/y date string, one character per request, and checks it.
// ---------------------------------------------------------------------------
// Usage:
//   char_ch carries one ASCII character per request, last_char set on the
//   final character of a string. One result per string appears on date_ch:
//   day, month, year (all zero after a parse error) and date_ok.
//   Throughput: one character per cycle while the request queue is not full;
//   the parser updates its field accumulator once per accepted character.
//   The request for a string is written into the queue when its final
//   character is accepted; the validator then loads the result register
//   from the queue head, and the result register drives date_ch.
//   A two-entry queue decouples the parser from the validator; when the
//   receiver holds date_ch.ready low the result register holds, the queue
//   fills, and char_ch.ready drops only when both queue entries are taken.
//   Reset (rst, synchronous) returns the parser to the day field, empties
//   the queue and drops date_ch.valid.
// ---------------------------------------------------------------------------
module date_text_parse_validate_top (
  input  logic        clk,
  input  logic        rst,
  dtpv_char_if.sink   char_ch,
  dtpv_date_if.source date_ch
);

  logic                q_full;
  logic                push;
  dtpv_pkg::date_req_t push_data;
  logic                pop;
  logic                head_valid;
  dtpv_pkg::date_req_t head_data;

  dtpv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_ch   (char_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  dtpv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  dtpv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .date_ch    (date_ch)
  );

endmodule

/* rtl/dtpv_checker.sv */
// ---------------------------------------------------------------------------
// dtpv_checker
// Port-level checks on the date result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "date_text_parse_validate_top_macros.svh"

module dtpv_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         date_ok,
  input logic [dtpv_pkg::DAY_W-1:0]   day_out,
  input logic [dtpv_pkg::MONTH_W-1:0] month_out,
  input logic [dtpv_pkg::YEAR_W-1:0]  year_out
);

  `DTPV_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(date_ok) && $stable(day_out) && $stable(month_out) && $stable(year_out), "result changed while stalled")

  `DTPV_ASSERT_NOW(a_ok_fields, out_valid && date_ok, day_out != '0 && day_out <= 7'd31 && month_out != '0 && month_out <= dtpv_pkg::MONTH_MAX, "valid date with bad day or month")

  `DTPV_ASSERT_NOW(a_ok_year, out_valid && date_ok, year_out >= dtpv_pkg::YEAR_MIN && year_out <= dtpv_pkg::YEAR_MAX, "valid date with year out of range")

  `DTPV_ASSERT_NEXT_ALWAYS(a_reset_idle, rst, !out_valid, "result valid after reset")

endmodule

bind date_text_parse_validate_top dtpv_checker u_dtpv_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (date_ch.valid),
  .out_ready (date_ch.ready),
  .date_ok   (date_ch.date_ok),
  .day_out   (date_ch.day_out),
  .month_out (date_ch.month_out),
  .year_out  (date_ch.year_out)
);

/* verif/tb_date_text_parse_validate_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_date_text_parse_validate_top
// Streams d/m/y date text into the parser one character per request and
// checks each emitted date against a cycle-free model of the parse and of
// the Gregorian check. Directed corner strings first, then random strings,
// mostly well formed, with random idle on both channels.
// ---------------------------------------------------------------------------
module tb_date_text_parse_validate_top;

  typedef struct {
    bit                           ok;
    logic [dtpv_pkg::DAY_W-1:0]   day;
    logic [dtpv_pkg::MONTH_W-1:0] month;
    logic [dtpv_pkg::YEAR_W-1:0]  year;
  } parsed_date_t;

  class date_parse_tracker;
    logic [dtpv_pkg::FIELD_W-1:0] field;
    logic [dtpv_pkg::DCNT_W-1:0]  ndigits;
    logic [dtpv_pkg::YEAR_W-1:0]  acc;
    logic [dtpv_pkg::DAY_W-1:0]   day_held;
    logic [dtpv_pkg::MONTH_W-1:0] month_held;
    bit                           bad;
    parsed_date_t                 dates_due[$];
    int                           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      field = dtpv_pkg::FLD_DAY;
      ndigits = '0;
      acc = '0;
      day_held = '0;
      month_held = '0;
      bad = 1'b0;
    endfunction

    // year value stays in acc once the year field closes
    function void close_field();
      if (field == dtpv_pkg::FLD_DAY || field == dtpv_pkg::FLD_MONTH) begin
        if (ndigits > dtpv_pkg::DCNT_MAX_DM) bad = 1'b1;
        else if (field == dtpv_pkg::FLD_DAY) day_held = acc[dtpv_pkg::DAY_W-1:0];
        else month_held = acc[dtpv_pkg::MONTH_W-1:0];
        acc = '0;
        ndigits = '0;
        field = field + 1'b1;
      end else if (field == dtpv_pkg::FLD_YEAR) begin
        if (ndigits != dtpv_pkg::DCNT_YEAR_S && ndigits != dtpv_pkg::DCNT_YEAR_L) bad = 1'b1;
        field = dtpv_pkg::FLD_DONE;
      end
    endfunction

    function void take_char(logic [dtpv_pkg::CHAR_W-1:0] c, logic last);
      parsed_date_t r;
      int unsigned  y;
      int unsigned  mlen;
      bit           leap;
      if (field != dtpv_pkg::FLD_DONE) begin
        if (c == dtpv_pkg::CHAR_SLASH) begin
          close_field();
        end else if (c >= dtpv_pkg::CHAR_ZERO && c <= dtpv_pkg::CHAR_NINE) begin
          if (ndigits < dtpv_pkg::DCNT_ACC_LIM)
            acc = dtpv_pkg::YEAR_W'(acc * 10 + (c - dtpv_pkg::CHAR_ZERO));
          if (ndigits != dtpv_pkg::DCNT_SAT) ndigits = ndigits + 1'b1;
        end else begin
          bad = 1'b1;
          field = dtpv_pkg::FLD_DONE;
        end
      end
      if (!last) return;
      // text ended before the year field: empty year
      if (field == dtpv_pkg::FLD_DAY || field == dtpv_pkg::FLD_MONTH) bad = 1'b1;
      else if (field == dtpv_pkg::FLD_YEAR) close_field();
      if (bad) begin
        r.day = '0;
        r.month = '0;
        r.year = '0;
      end else begin
        r.day = day_held;
        r.month = month_held;
        r.year = acc;
      end
      y = r.year;
      leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
      case (r.month)
        7'd2:                      mlen = leap ? 29 : 28;
        7'd4, 7'd6, 7'd9, 7'd11:   mlen = 30;
        7'd1, 7'd3, 7'd5, 7'd7,
        7'd8, 7'd10, 7'd12:        mlen = 31;
        default:                   mlen = 0;
      endcase
      r.ok = (y >= dtpv_pkg::YEAR_MIN) && (y <= dtpv_pkg::YEAR_MAX) &&
             (r.day >= 1) && (r.day <= mlen);
      dates_due.push_back(r);
      restart();
    endfunction

    function void check_date(logic ok, logic [dtpv_pkg::DAY_W-1:0] d,
                             logic [dtpv_pkg::MONTH_W-1:0] m,
                             logic [dtpv_pkg::YEAR_W-1:0] y);
      parsed_date_t r;
      if (dates_due.size() == 0) begin
        $error("date result with no string pending: ok=%0d %0d/%0d/%0d", ok, d, m, y);
        errors++;
        return;
      end
      r = dates_due.pop_front();
      if (ok !== r.ok) begin
        $error("date_ok: expected %0d, got %0d", r.ok, ok);
        errors++;
      end
      if (d !== r.day) begin
        $error("day_out: expected %0d, got %0d", r.day, d);
        errors++;
      end
      if (m !== r.month) begin
        $error("month_out: expected %0d, got %0d", r.month, m);
        errors++;
      end
      if (y !== r.year) begin
        $error("year_out: expected %0d, got %0d", r.year, y);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   idling_on = 1'b1;
  int   chars_sent = 0;

  date_parse_tracker tracker = new();

  dtpv_char_if char_ch();
  dtpv_date_if date_ch();

  date_text_parse_validate_top dut (
    .clk     (clk),
    .rst     (rst),
    .char_ch (char_ch),
    .date_ch (date_ch)
  );

  always #6 clk = ~clk;

  // one character per request; valid stays high across back-to-back requests
  task automatic send_char(input logic [dtpv_pkg::CHAR_W-1:0] c, input logic last);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.char_code <= c;
    char_ch.last_char <= last;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    tracker.take_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(ref logic [dtpv_pkg::CHAR_W-1:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  function automatic void push_num(ref logic [dtpv_pkg::CHAR_W-1:0] txt[$],
                                   input int unsigned value, input int ndig);
    for (int k = ndig - 1; k >= 0; k--)
      txt.push_back(dtpv_pkg::CHAR_W'(dtpv_pkg::CHAR_ZERO + (value / (10 ** k)) % 10));
  endfunction

  function automatic void make_date_text(ref logic [dtpv_pkg::CHAR_W-1:0] txt[$]);
    int          kind;
    int unsigned dd, mm, yy;
    int          dn, mn, yn, sel;
    txt.delete();
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      // raw noise: random codes, slashes and digits
      repeat ($urandom_range(1, 8)) begin
        sel = $urandom_range(0, 3);
        if (sel == 0) txt.push_back(dtpv_pkg::CHAR_W'($urandom_range(0, 255)));
        else if (sel == 1) txt.push_back(dtpv_pkg::CHAR_SLASH);
        else txt.push_back(dtpv_pkg::CHAR_W'(dtpv_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end
      return;
    end
    case ($urandom_range(0, 5))
      0:       dd = $urandom_range(0, 99);
      1, 2:    dd = $urandom_range(28, 31);
      default: dd = $urandom_range(1, 28);
    endcase
    mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 7))
      0:       yy = $urandom_range(0, 99) * 100;
      1:       yy = $urandom_range(0, 24) * 400;
      2:       yy = $urandom_range(0, 2499) * 4;
      3: begin
        sel = $urandom_range(0, 3);
        yy = (sel == 0) ? 0 : (sel == 1) ? 9 : (sel == 2) ? 10 : 9999;
      end
      default: yy = $urandom_range(0, 9999);
    endcase
    dn = (dd > 9) ? 2 : (dd == 0 && $urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 2);
    mn = (mm > 9) ? 2 : (mm == 0 && $urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 2);
    yn = ($urandom_range(0, 2) == 0) ? 2 : 4;
    if (yn == 2) yy = yy % 100;
    if (kind == 6) begin
      // wrong digit counts, including year runs past the counter limit
      case ($urandom_range(0, 2))
        0: dn = 3;
        1: mn = 3;
        default: begin
          sel = $urandom_range(0, 6);
          yn = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 3 : sel + 2;
          yy = (yn == 0) ? 0 : $urandom % (10 ** yn);
        end
      endcase
    end
    push_num(txt, dd, dn);
    txt.push_back(dtpv_pkg::CHAR_SLASH);
    push_num(txt, mm, mn);
    txt.push_back(dtpv_pkg::CHAR_SLASH);
    push_num(txt, yy, yn);
    if ($urandom_range(0, 4) == 0) begin
      txt.push_back(dtpv_pkg::CHAR_SLASH);
      repeat ($urandom_range(0, 3)) txt.push_back(dtpv_pkg::CHAR_W'($urandom_range(0, 255)));
    end
    if (kind == 7) begin
      sel = $urandom_range(1, txt.size());
      while (txt.size() > sel) void'(txt.pop_back());
    end else if (kind == 9) begin
      txt[$urandom_range(0, txt.size() - 1)] = dtpv_pkg::CHAR_W'($urandom_range(0, 255));
    end
  endfunction

  // result side: check on every accepted result, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    date_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && date_ch.valid && date_ch.ready)
        tracker.check_date(date_ch.date_ok, date_ch.day_out, date_ch.month_out,
                           date_ch.year_out);
      if (stall_left > 0) stall_left--;
      else if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      date_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    logic [dtpv_pkg::CHAR_W-1:0] txt[$];
    string                       corner_dates[4];
    corner_dates = '{"//12345", "9/9/99/z", "29/2/00", "31/12/9999"};
    rst = 1'b1;
    char_ch.valid = 1'b0;
    char_ch.char_code = '0;
    char_ch.last_char = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // lone out-of-range codes end the string before the year
    txt = '{8'hFF};
    send_text(txt);
    txt = '{8'h00};
    send_text(txt);
    foreach (corner_dates[n]) begin
      txt.delete();
      for (int i = 0; i < corner_dates[n].len(); i++) txt.push_back(corner_dates[n][i]);
      send_text(txt);
    end

    while (chars_sent < 550) begin
      if (chars_sent > 450) idling_on = 1'b0;
      make_date_text(txt);
      send_text(txt);
    end
    char_ch.valid <= 1'b0;
    char_ch.last_char <= 1'b0;

    while (tracker.dates_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
